/* design/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock outside reset
`define TLFD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TLFD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/tlfd_pkg.sv */
package tlfd_pkg;

  localparam int TYPE_W = 32;
  localparam int LEN_W  = 32;
  localparam int REM_W  = 21;

  // header layout: 4 length bytes, 2 tag bytes, 4 type bytes
  localparam logic [3:0] LEN_BYTES    = 4'd4;
  localparam logic [3:0] TAG_END      = 4'd6;
  localparam logic [3:0] HEADER_BYTES = 4'd10;
  localparam logic [3:0] LAST_HDR_IDX = 4'd9;

  localparam logic [LEN_W-1:0] NON_PAYLOAD_LEN = 32'd6;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD     = 32'd1048576;

  localparam logic [7:0] TAG_RESET = 8'd10;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_TAG = 2'd2,
    KIND_BAD_LEN = 2'd3
  } kind_t;

endpackage

/* design/tagged_length_frame_deframer.sv */
// tagged length-prefixed frame deframer
// input channel: one received stream byte per transaction on data_byte,
//   handshake in_valid / in_stall
// output channel: one result per transaction on result_kind, payload_byte,
//   frame_type, last_of_frame, handshake out_valid / out_stall
// config: cfg_wr_en writes cfg_wr_data into the tag register (reset 10);
//   write only while no transaction is in flight
// each frame is a 10-byte header (big-endian length, two tag bytes,
//   big-endian type) and then payload; every payload byte gives a result,
//   header bytes give none except the last one when the header is bad
//   or the frame is empty
// throughput: one byte per cycle while out_stall does not hold the result
//   register; the state update between the input register and the result register is combinational
// a taken byte waits in the input register; its result is registered into
//   the result register and out_valid once that register is free
// out_stall holds the result register; the input register then fills and
//   in_stall rises in the same cycle, so nothing is dropped
// rst (synchronous) empties both registers, restarts the header hunt and
//   sets the tag back to 10
module tagged_length_frame_deframer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [7:0]                        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        data_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        result_kind,
  output logic [7:0]                        payload_byte,
  output logic signed [tlfd_pkg::TYPE_W-1:0] frame_type,
  output logic                              last_of_frame
);
  import tlfd_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // configuration
  logic [7:0] tag_value;

  // deframer state
  logic              in_payload, in_payload_next;
  logic [3:0]        header_index, header_index_next;
  logic [LEN_W-1:0]  length_field, length_field_next;
  logic              tag_ok, tag_ok_next;
  logic [TYPE_W-1:0] type_field, type_field_next;
  logic [REM_W-1:0]  bytes_remaining, bytes_remaining_next;

  // result being formed
  logic              emit;
  kind_t             kind_next;
  logic [7:0]        payload_byte_next;
  logic [TYPE_W-1:0] frame_type_next;
  logic              last_next;

  logic              out_free;
  logic              advance;
  logic              last_pay;
  logic [LEN_W-1:0]  payload_len;
  logic              length_ok;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  assign last_pay    = (bytes_remaining <= {{(REM_W-1){1'b0}}, 1'b1});
  assign payload_len = length_field - NON_PAYLOAD_LEN;
  // legal lengths cover the six header bytes after the length field
  assign length_ok   = (length_field >= NON_PAYLOAD_LEN) && (payload_len <= MAX_PAYLOAD);

  always_comb begin
    in_payload_next      = in_payload;
    header_index_next    = header_index;
    length_field_next    = length_field;
    tag_ok_next          = tag_ok;
    type_field_next      = type_field;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    kind_next            = KIND_PAYLOAD;
    payload_byte_next    = 8'd0;
    frame_type_next      = '0;
    last_next            = 1'b0;

    if (advance) begin
      if (in_payload) begin
        emit              = 1'b1;
        kind_next         = KIND_PAYLOAD;
        payload_byte_next = s1_byte;
        frame_type_next   = type_field;
        last_next         = last_pay;
        if (last_pay) begin
          in_payload_next      = 1'b0;
          header_index_next    = '0;
          length_field_next    = '0;
          tag_ok_next          = 1'b1;
          type_field_next      = '0;
          bytes_remaining_next = '0;
        end else begin
          bytes_remaining_next = bytes_remaining - {{(REM_W-1){1'b0}}, 1'b1};
        end
      end else begin
        // shift the byte into its header field
        if (header_index < LEN_BYTES) begin
          length_field_next = {length_field[LEN_W-9:0], s1_byte};
        end else if (header_index < TAG_END) begin
          if (s1_byte != tag_value) begin
            tag_ok_next = 1'b0;
          end
        end else begin
          type_field_next = {type_field[TYPE_W-9:0], s1_byte};
        end

        if (header_index != LAST_HDR_IDX) begin
          header_index_next = header_index + 4'd1;
        end else begin
          // full header in hand: judge it, tag first
          header_index_next    = '0;
          length_field_next    = '0;
          tag_ok_next          = 1'b1;
          type_field_next      = '0;
          bytes_remaining_next = '0;
          if (!tag_ok) begin
            emit      = 1'b1;
            kind_next = KIND_BAD_TAG;
          end else if (!length_ok) begin
            emit      = 1'b1;
            kind_next = KIND_BAD_LEN;
          end else if (length_field == NON_PAYLOAD_LEN) begin
            emit            = 1'b1;
            kind_next       = KIND_EMPTY;
            frame_type_next = {type_field[TYPE_W-9:0], s1_byte};
            last_next       = 1'b1;
          end else begin
            // keep the type, count down the payload
            in_payload_next      = 1'b1;
            type_field_next      = {type_field[TYPE_W-9:0], s1_byte};
            bytes_remaining_next = payload_len[REM_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      tag_value       <= TAG_RESET;
      in_payload      <= 1'b0;
      header_index    <= '0;
      length_field    <= '0;
      tag_ok          <= 1'b1;
      type_field      <= '0;
      bytes_remaining <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tag_value <= cfg_wr_data;
      end

      // input register takes a byte whenever it is empty or draining
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      in_payload      <= in_payload_next;
      header_index    <= header_index_next;
      length_field    <= length_field_next;
      tag_ok          <= tag_ok_next;
      type_field      <= type_field_next;
      bytes_remaining <= bytes_remaining_next;

      if (out_free) begin
        out_valid <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
    end
    if (emit) begin
      result_kind   <= kind_next;
      payload_byte  <= payload_byte_next;
      frame_type    <= frame_type_next;
      last_of_frame <= last_next;
    end
  end

`include "assert_macros.svh"

  `TLFD_ASSERT_IMPLIES(a_payload_count, in_payload, bytes_remaining != '0, "payload with zero count")
  `TLFD_ASSERT_IMPLIES(a_hdr_idx, !in_payload, header_index < HEADER_BYTES, "header index overrun")
  `TLFD_ASSERT_IMPLIES(a_payload_no_hdr, in_payload, header_index == '0, "header index in payload")
  `TLFD_ASSERT_IMPLIES(a_last_kind, out_valid && last_of_frame, result_kind == KIND_PAYLOAD || result_kind == KIND_EMPTY, "last on error result")
  `TLFD_ASSERT_IMPLIES(a_err_zero, out_valid && (result_kind == KIND_BAD_TAG || result_kind == KIND_BAD_LEN), payload_byte == 8'd0 && frame_type == '0, "error result carries data")

endmodule
